// File: design/heq_pkg.sv
// Shared types and constants for the histogram equalizer.
// Used by heq_term_div and histogram_equalizer_unit; depends on nothing.

package heq_pkg;

   // Gray levels and histogram bins
   localparam int BIN_W     = 8;
   localparam int BINS      = 1 << BIN_W;
   localparam int CNT_W     = 21;
   localparam logic [CNT_W-1:0] BIN_MAX = {CNT_W{1'b1}};

   // Divisor register
   localparam int TOT_W = 21;
   localparam logic [TOT_W-1:0] TOTAL_RESET = TOT_W'(262144);

   // Default number of output levels
   localparam int LEVELS_DEFAULT = 256;

   // Rounding divider: denominator is twice the pixel total, quotient is
   // computed to QUO_W bits and anything larger is reported as TERM_SAT.
   localparam int DEN_W   = TOT_W + 1;
   localparam int QUO_W   = 9;
   localparam int QCNT_W  = $clog2(QUO_W);
   localparam int REM_W   = DEN_W + QUO_W;
   localparam int TERM_W  = QUO_W + 1;
   localparam logic [TERM_W-1:0] TERM_SAT = TERM_W'(1) << QUO_W;

   // Command codes
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_COUNT = 2'd1,
      CMD_BUILD = 2'd2,
      CMD_MAP   = 2'd3
   } cmd_type;

   // Divider status back to the build sequencer
   typedef struct packed {
      logic              done;
      logic [TERM_W-1:0] term;
   } heq_div_res_type;

endpackage

// File: design/heq_term_div.sv
// Rounding divider for one histogram bin term: floor(numer / denom), one
// quotient bit per cycle, saturated to TERM_SAT. Depends on heq_pkg.

module heq_term_div
   import heq_pkg::*;
#(
   parameter int NUM_W = 35
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      numer,
   input  logic [DEN_W-1:0]      denom,
   output heq_div_res_type       res
);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [REM_W-1:0]    dsh_ff, dsh_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [TERM_W-1:0]   term_ff, term_in;

   logic                sat;
   logic                ge;
   logic [QUO_W-1:0]    quo_next;

   // Quotient would not fit in QUO_W bits: report saturation at once
   assign sat      = numer >= NUM_W'({denom, {QUO_W{1'b0}}});
   assign ge       = rem_ff >= dsh_ff;
   assign quo_next = {quo_ff[QUO_W-2:0], ge};

   // Restoring division, top quotient bit first
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      term_in = term_ff;
      if (start) begin
         if (sat) begin
            term_in = TERM_SAT;
            done_in = 1'b1;
         end else begin
            run_in = 1'b1;
            cnt_in = QCNT_W'(QUO_W - 1);
            rem_in = numer[REM_W-1:0];
            dsh_in = REM_W'({denom, {(QUO_W-1){1'b0}}});
            quo_in = '0;
         end
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = quo_next;
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            term_in = TERM_W'(quo_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      term_ff <= term_in;
   end

   assign res.done = done_ff;
   assign res.term = term_ff;

endmodule

// File: design/histogram_equalizer_unit.sv
// Top level of the histogram equalizer: histogram and level map memories,
// count pipeline, map lookup and the map build sequencer.
// Depends on heq_pkg and heq_term_div.
//
// Usage:
//   A command beat is taken when start is high and busy is low. It carries
//   req_command (clear, count, build, map) and req_pixel.
//   Clear, count and map may follow back to back.
//   Count is a read-modify-write of the histogram memory;
//   a count right behind another count to the same bin is forwarded.
//   Clear drops every bin at once through per-bin valid bits.
//   Map reads the level map and shows the result on rsp_mapped_pixel with
//   rsp_strobe high for exactly one cycle, in the cycle after the beat. The
//   receiver cannot stall; results are never held.
//   Build raises busy and walks the 256 bins. Each bin takes one memory read,
//   one multiply, and the bit-serial rounding divider, which skips its
//   iterations when the term saturates; then the map entry is written.
//   The map may be read only after a build.
//   total_pixels is written on the csr_ channel while idle; csr_ready is low
//   during a build.
//   Reset (synchronous, active high) empties the histogram, sets the pixel
//   total to 262144 and returns the sequencer to idle.

module histogram_equalizer_unit
   import heq_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [BIN_W-1:0]   req_pixel,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_mapped_pixel,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [TOT_W-1:0]   csr_total_pixels
);

   localparam int MW    = $clog2(LEVELS);
   localparam int NUM_W = (MW + 23 > 32) ? MW + 23 : 32;
   localparam logic [NUM_W-1:0] MULT2 = NUM_W'(2 * (LEVELS - 1));
   localparam int CAP_I = (LEVELS - 1 < 255) ? LEVELS - 1 : 255;
   localparam logic [7:0] CAP = 8'(CAP_I);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_START = 6'b001000,
      ST_WAIT  = 6'b010000,
      ST_WRITE = 6'b100000
   } bld_state_type;

   // Storage
   logic [CNT_W-1:0]   hist_mem_ff [BINS];
   logic [BINS-1:0]    hist_vld_ff;
   logic [7:0]         map_mem_ff [BINS];

   logic [TOT_W-1:0]   total_ff;
   bld_state_type      state_ff, state_in;
   logic [BIN_W-1:0]   idx_ff, idx_in;
   logic [7:0]         sum_ff, sum_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [TERM_W-1:0]  term_ff, term_in;

   logic [CNT_W-1:0]   hist_q_ff;
   logic               rd_hit_ff;
   logic               cnt_vld_ff;
   logic [BIN_W-1:0]   cnt_addr_ff;
   logic               last_vld_ff;
   logic [BIN_W-1:0]   last_addr_ff;
   logic [CNT_W-1:0]   last_data_ff;
   logic               rsp_strobe_ff;
   logic [7:0]         map_q_ff;

   logic               accept;
   cmd_type            cmd;
   logic               clear_acc, count_acc, build_acc, map_acc;
   logic [BIN_W-1:0]   rd_addr;
   logic               fwd;
   logic [CNT_W-1:0]   cur_bin, inc_bin;
   logic [CNT_W-1:0]   hist_val;
   logic [TOT_W-1:0]   t_eff;
   logic [10:0]        sum_wide;
   logic [7:0]         sum_sat;
   logic               div_start;
   heq_div_res_type    div_res;

   // Command decode
   assign busy      = ~state_ff[0];
   assign accept    = start & ~busy;
   assign cmd       = cmd_type'(req_command);
   assign clear_acc = accept && (cmd == CMD_CLEAR);
   assign count_acc = accept && (cmd == CMD_COUNT);
   assign build_acc = accept && (cmd == CMD_BUILD);
   assign map_acc   = accept && (cmd == CMD_MAP);
   assign csr_ready = ~busy;

   // Pixel total register
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
      end else if (csr_valid && csr_ready) begin
         total_ff <= csr_total_pixels;
      end
   end

   // Histogram read port, shared by count beats and the build walk
   assign rd_addr = busy ? idx_ff : req_pixel;

   always_ff @(posedge clock) begin
      hist_q_ff <= hist_mem_ff[rd_addr];
      rd_hit_ff <= hist_vld_ff[rd_addr];
   end

   // Count write stage: forward the previous write, saturating increment
   assign fwd     = last_vld_ff && (last_addr_ff == cnt_addr_ff);
   assign cur_bin = fwd ? last_data_ff : (rd_hit_ff ? hist_q_ff : '0);
   assign inc_bin = (cur_bin == BIN_MAX) ? cur_bin : cur_bin + 1'b1;

   always_ff @(posedge clock) begin
      if (cnt_vld_ff) begin
         hist_mem_ff[cnt_addr_ff] <= inc_bin;
      end
   end

   // Clear wins over a write landing at the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
      end else if (clear_acc) begin
         hist_vld_ff <= '0;
      end else if (cnt_vld_ff) begin
         hist_vld_ff[cnt_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff  <= 1'b0;
         last_vld_ff <= 1'b0;
      end else begin
         cnt_vld_ff  <= count_acc;
         last_vld_ff <= cnt_vld_ff & ~clear_acc;
      end
   end

   always_ff @(posedge clock) begin
      cnt_addr_ff  <= req_pixel;
      last_addr_ff <= cnt_addr_ff;
      last_data_ff <= inc_bin;
   end

   // Map lookup, registered result in the following cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= map_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (map_acc) begin
         map_q_ff <= map_mem_ff[req_pixel];
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_mapped_pixel = map_q_ff;

   // Build datapath
   assign hist_val  = rd_hit_ff ? hist_q_ff : '0;
   assign t_eff     = (total_ff == '0) ? TOT_W'(1) : total_ff;
   assign sum_wide  = 11'(sum_ff) + 11'(term_ff);
   assign sum_sat   = (sum_wide > 11'(CAP)) ? CAP : sum_wide[7:0];
   assign div_start = state_ff[3];

   heq_term_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (num_ff),
      .denom ({t_eff, 1'b0}),
      .res   (div_res)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         map_mem_ff[idx_ff] <= sum_sat;
      end
   end

   // Build sequencer: read, multiply, divide, accumulate, next bin
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      num_in   = num_ff;
      term_in  = term_ff;
      case (state_ff)
         ST_IDLE: begin
            if (build_acc) begin
               state_in = ST_READ;
               idx_in   = '0;
               sum_in   = '0;
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            num_in   = NUM_W'(hist_val) * MULT2 + NUM_W'(t_eff);
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_res.done) begin
               term_in  = div_res.term;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            sum_in = sum_sat;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == {BIN_W{1'b1}}) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      num_ff  <= num_in;
      term_ff <= term_in;
   end

endmodule
